/* hw/rtl/lcdm_pkg.sv */
// Package for the LUT cut delay mapper: sizes, modes, state encoding and cut type.
package lcdm_pkg;
    localparam int NODE_COUNT  = 4096;
    localparam int MAX_LEAVES  = 6;
    localparam int ID_W        = 12;
    localparam int ADDR_W      = $clog2(NODE_COUNT);
    localparam int DLY_W       = 8;
    localparam int CNT_W       = 3;
    localparam int LEAVES_W    = ID_W * MAX_LEAVES;
    // node table entry: delay, leaf count, leaves
    localparam int ENTRY_W     = DLY_W + CNT_W + LEAVES_W;
    localparam logic [DLY_W-1:0] DLY_MAX = '1;

    localparam logic [1:0] MODE_DECL = 2'd0;
    localparam logic [1:0] MODE_MAP  = 2'd1;
    localparam logic [1:0] MODE_OUT  = 2'd2;

    localparam logic CFG_LEAF_LIMIT = 1'b0;
    localparam logic CFG_CUT_LIMIT  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE, ST_RD0, ST_RD1, ST_LV0, ST_LVW0, ST_LV1, ST_LVW1,
        ST_MERGE, ST_WRITE, ST_OUT
    } state_t;

    typedef struct packed {
        logic [CNT_W-1:0]            n;
        logic [MAX_LEAVES-1:0][ID_W-1:0] lv;
        logic [DLY_W-1:0]            dly;
    } cut_t;
endpackage

/* hw/rtl/lcdm_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
module lcdm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* hw/rtl/lut_cut_delay_mapper_unit.sv */
// LUT cut delay mapper: node table in RAM, sequential read-merge-write per node.
// Sequencing: modes 0, 2 and 3 go from the accept straight to the write and output step;
//   mode 1 first does two entry reads, a delay read for each stored leaf, a union of one leaf
//   per cycle for each of four cut pairs, and then the write back.
// Throughput: one transaction at a time; the next is accepted only after the result is
//   registered, and later while the previous result still waits on m_tready.
// Reset: synchronous active low; a clearing pass over the whole node table follows reset,
//   during which s_tready stays low. Configuration returns to leaf_limit 4, cut_limit 2.
module lut_cut_delay_mapper_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // mode[1:0], node_id[13:2], fanin0_id[25:14], fanin1_id[37:26], zero fill
    input  logic [39:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // result_node[11:0], cut_delay[19:12], leaf_count[22:20], leaf_a..leaf_f[94:23],
    // worst_output_delay[102:95], zero fill
    output logic [103:0] m_tdata,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [2:0]  cfg_wdata
);
    import lcdm_pkg::*;

    state_t state_reg, state_next;

    logic [2:0] leaf_limit_reg;
    logic [1:0] cut_limit_reg;
    logic [ADDR_W:0] clr_reg, clr_next;
    logic [1:0] mode_reg;
    logic [ID_W-1:0] node_reg, f0_reg, f1_reg;
    cut_t t0_reg, t1_reg, b0_reg, b1_reg, best_reg, best_next;
    logic have_b0_reg, have_b1_reg;
    logic [2:0] li_reg, li_next;
    logic [1:0] pi_reg, pi_next;
    logic have_reg, have_next;
    logic [DLY_W-1:0] worst_reg;
    logic [103:0] out_reg;
    logic out_valid_reg;

    // merge walk state
    logic [MAX_LEAVES-1:0][ID_W-1:0] mlv_reg, mlv_next;
    logic [2:0] mi_reg, mi_next, mk_reg, mk_next, mc_reg, mc_next;
    logic mfail_reg, mfail_next;

    // RAM port
    logic ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

    lcdm_ram #(.WIDTH(ENTRY_W), .DEPTH(NODE_COUNT)) u_table (
        .aclk(aclk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
        .raddr(ram_raddr), .rdata(ram_rdata)
    );

    logic [DLY_W-1:0] rd_dly;
    logic [CNT_W-1:0] rd_cnt;
    logic [LEAVES_W-1:0] rd_lv;
    assign {rd_dly, rd_cnt, rd_lv} = ram_rdata;

    logic [2:0] limit;
    always_comb begin
        limit = leaf_limit_reg;
        if (limit < 3'd2) limit = 3'd2;
        if (limit > 3'(MAX_LEAVES)) limit = 3'(MAX_LEAVES);
    end

    // Sorted union of the current cut pair, one leaf per cycle
    cut_t ma, mb;
    logic p_valid, m_more, take_a, take_b;
    logic [ID_W-1:0] mv;
    logic [DLY_W-1:0] m_max, m_dly;
    always_comb begin
        ma = pi_reg[1] ? b0_reg : t0_reg;
        mb = pi_reg[0] ? b1_reg : t1_reg;
        p_valid = (!pi_reg[1] || have_b0_reg) && (!pi_reg[0] || have_b1_reg);
        m_more = (mi_reg < ma.n) || (mk_reg < mb.n);
        take_a = (mk_reg >= mb.n) || ((mi_reg < ma.n) && (ma.lv[mi_reg] < mb.lv[mk_reg]));
        take_b = !take_a && ((mi_reg >= ma.n) || (mb.lv[mk_reg] < ma.lv[mi_reg]));
        mv = take_b ? mb.lv[mk_reg] : ma.lv[mi_reg];
        m_max = (ma.dly > mb.dly) ? ma.dly : mb.dly;
        m_dly = (m_max == DLY_MAX) ? DLY_MAX : m_max + 8'd1;
    end

    logic s_fire, m_fire;
    assign s_fire = s_tvalid && s_tready;
    assign m_fire = m_tvalid && m_tready;
    assign s_tready = (state_reg == ST_IDLE) && clr_reg[ADDR_W];
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    // Control and datapath sequencing
    logic [ID_W-1:0] cur_leaf;
    always_comb begin
        state_next = state_reg;
        clr_next   = clr_reg;
        li_next    = li_reg;
        pi_next    = pi_reg;
        have_next  = have_reg;
        best_next  = best_reg;
        mi_next    = mi_reg;
        mk_next    = mk_reg;
        mc_next    = mc_reg;
        mfail_next = mfail_reg;
        mlv_next   = mlv_reg;
        ram_we     = 1'b0;
        ram_waddr  = node_reg[ADDR_W-1:0];
        ram_wdata  = '0;
        ram_raddr  = node_reg[ADDR_W-1:0];
        cur_leaf   = '0;
        if (!clr_reg[ADDR_W]) begin
            ram_we    = 1'b1;
            ram_waddr = clr_reg[ADDR_W-1:0];
            clr_next  = clr_reg + 1'b1;
        end
        case (state_reg)
            ST_IDLE: begin
                ram_raddr = s_tdata[2 +: ADDR_W];
                best_next = '0;
                if (s_fire) begin
                    state_next = (s_tdata[1:0] == MODE_MAP) ? ST_RD0 : ST_WRITE;
                end
            end
            ST_RD0: begin
                ram_raddr = f0_reg[ADDR_W-1:0];
                state_next = ST_RD1;
            end
            ST_RD1: begin
                ram_raddr = f1_reg[ADDR_W-1:0];
                li_next = '0;
                state_next = ST_LV0;
            end
            ST_LV0: begin
                // b0 captured here; issue delay reads for its leaves
                cur_leaf = b0_reg.lv[li_reg];
                ram_raddr = cur_leaf[ADDR_W-1:0];
                if (!have_b0_reg || li_reg >= b0_reg.n) begin
                    li_next = '0;
                    state_next = ST_LV1;
                end else begin
                    state_next = ST_LVW0;
                end
            end
            ST_LVW0: begin
                li_next = li_reg + 3'd1;
                state_next = ST_LV0;
            end
            ST_LV1: begin
                cur_leaf = b1_reg.lv[li_reg];
                ram_raddr = cur_leaf[ADDR_W-1:0];
                if (!have_b1_reg || li_reg >= b1_reg.n) begin
                    pi_next = '0;
                    have_next = 1'b0;
                    mi_next = '0;
                    mk_next = '0;
                    mc_next = '0;
                    mfail_next = 1'b0;
                    mlv_next = '0;
                    state_next = ST_MERGE;
                end else begin
                    state_next = ST_LVW1;
                end
            end
            ST_LVW1: begin
                li_next = li_reg + 3'd1;
                state_next = ST_LV1;
            end
            ST_MERGE: begin
                if (p_valid && m_more && !mfail_reg) begin
                    // place the next leaf of the union
                    mi_next = mi_reg + {2'b0, !take_b};
                    mk_next = mk_reg + {2'b0, !take_a};
                    if (mc_reg >= limit) begin
                        mfail_next = 1'b1;
                    end else begin
                        mlv_next[mc_reg] = mv;
                        mc_next = mc_reg + 3'd1;
                    end
                end else begin
                    // pair finished: keep it if it beats the best so far
                    if (p_valid && !mfail_reg && (!have_reg || m_dly < best_reg.dly ||
                        (m_dly == best_reg.dly && mc_reg < best_reg.n))) begin
                        best_next.n   = mc_reg;
                        best_next.lv  = mlv_reg;
                        best_next.dly = m_dly;
                        have_next = 1'b1;
                    end
                    mi_next = '0;
                    mk_next = '0;
                    mc_next = '0;
                    mfail_next = 1'b0;
                    mlv_next = '0;
                    pi_next = pi_reg + 2'd1;
                    if (pi_reg == 2'd3) state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                // mode 0/2 have their entry in rd_* now (read issued at accept)
                if (mode_reg == MODE_DECL) begin
                    ram_we = 1'b1;
                    ram_wdata = '0;
                end else if (mode_reg == MODE_MAP) begin
                    ram_we = 1'b1;
                    ram_wdata = {best_reg.dly, best_reg.n, best_reg.lv};
                end
                if (!out_valid_reg || m_fire) state_next = ST_OUT;
            end
            ST_OUT: begin
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Registers
    logic [DLY_W-1:0] new_worst, out_dly;
    logic [CNT_W-1:0] out_cnt;
    logic [LEAVES_W-1:0] out_lv;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            clr_reg        <= '0;
            leaf_limit_reg <= 3'd4;
            cut_limit_reg  <= 2'd2;
            worst_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            if (cfg_we) begin
                if (cfg_index == CFG_LEAF_LIMIT) leaf_limit_reg <= cfg_wdata;
                else                              cut_limit_reg  <= cfg_wdata[1:0];
            end
            if (state_reg == ST_WRITE && (!out_valid_reg || m_fire)) begin
                out_valid_reg <= 1'b1;
                if (mode_reg == MODE_OUT && rd_dly > worst_reg) worst_reg <= rd_dly;
            end else if (m_fire) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        new_worst = worst_reg;
        out_dly   = '0;
        out_cnt   = '0;
        out_lv    = '0;
        if (mode_reg == MODE_OUT) begin
            out_dly = rd_dly;
            if (rd_dly > worst_reg) new_worst = rd_dly;
        end else if (mode_reg == MODE_MAP) begin
            out_dly = best_reg.dly;
            out_cnt = best_reg.n;
            out_lv  = best_reg.lv;
        end
    end

    always_ff @(posedge aclk) begin
        li_reg    <= li_next;
        pi_reg    <= pi_next;
        have_reg  <= have_next;
        best_reg  <= best_next;
        mi_reg    <= mi_next;
        mk_reg    <= mk_next;
        mc_reg    <= mc_next;
        mfail_reg <= mfail_next;
        mlv_reg   <= mlv_next;
        if (s_fire) begin
            mode_reg <= s_tdata[1:0];
            node_reg <= s_tdata[13:2];
            f0_reg   <= s_tdata[25:14];
            f1_reg   <= s_tdata[37:26];
        end
        if (state_reg == ST_RD1) begin
            // fanin 0 entry
            t0_reg.n   <= 3'd1;
            t0_reg.lv  <= LEAVES_W'(f0_reg);
            t0_reg.dly <= rd_dly;
            b0_reg.n   <= (rd_cnt > 3'(MAX_LEAVES)) ? 3'(MAX_LEAVES) : rd_cnt;
            b0_reg.lv  <= rd_lv;
            b0_reg.dly <= '0;
            have_b0_reg <= (cut_limit_reg >= 2'd2) && (rd_cnt != '0);
        end
        if (state_reg == ST_LV0 && li_reg == 3'd0) begin
            // fanin 1 entry, present only on the first pass through ST_LV0
            t1_reg.n   <= 3'd1;
            t1_reg.lv  <= LEAVES_W'(f1_reg);
            t1_reg.dly <= rd_dly;
            b1_reg.n   <= (rd_cnt > 3'(MAX_LEAVES)) ? 3'(MAX_LEAVES) : rd_cnt;
            b1_reg.lv  <= rd_lv;
            b1_reg.dly <= '0;
            have_b1_reg <= (cut_limit_reg >= 2'd2) && (rd_cnt != '0);
        end
        if (state_reg == ST_LVW0 && rd_dly > b0_reg.dly) b0_reg.dly <= rd_dly;
        if (state_reg == ST_LVW1 && rd_dly > b1_reg.dly) b1_reg.dly <= rd_dly;
        if (state_reg == ST_WRITE && (!out_valid_reg || m_fire)) begin
            out_reg <= {1'b0, new_worst, out_lv, out_cnt, out_dly, node_reg};
        end
    end
endmodule

/* hw/rtl/lcdm_checker.sv */
// Port-level checker for the LUT cut delay mapper, bound to the top level.
module lcdm_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [39:0]  s_tdata,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [103:0] m_tdata
);
    // output stays until taken
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped or changed while stalled");
    // no new transaction the cycle after one is accepted
    a_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted back to back");
    // a result without leaves carries zero leaf fields and zero fill
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[22:20] == 3'd0) |-> (m_tdata[94:23] == '0) && !m_tdata[103])
        else $error("leaf fields set on a result without leaves");
    // leaf count bounded
    a_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[22:20] <= 3'd6)
        else $error("leaf count out of range");
endmodule

bind lut_cut_delay_mapper_unit lcdm_checker u_lcdm_checker (.*);

/* tb/sv/lut_cut_delay_mapper_unit_tb.sv */
// Testbench for the LUT cut delay mapper: directed and random node streams checked against a predictor.
`timescale 1ns / 1ps
module lut_cut_delay_mapper_unit_tb;
    import lcdm_pkg::*;

    typedef struct packed {
        logic [11:0] node;
        logic [7:0]  dly;
        logic [2:0]  cnt;
        logic [5:0][11:0] lv;
        logic [7:0]  worst;
    } map_result_t;

    typedef struct {
        int unsigned n;
        logic [11:0] lv[6];
        int unsigned dly;
    } tb_cut_t;

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [39:0]  s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [103:0] m_tdata;
    logic         cfg_we = 0;
    logic [0:0]   cfg_index = '0;
    logic [2:0]   cfg_wdata = '0;

    lut_cut_delay_mapper_unit DUT (.*);

    always begin
        #1 aclk = 1;
        #1 aclk = 0;
    end

    // predictor state
    logic [7:0]  tbl_delay[NODE_COUNT];
    logic [2:0]  tbl_count[NODE_COUNT];
    logic [11:0] tbl_leaves[NODE_COUNT][6];
    logic [7:0]  worst_seen;
    logic [2:0]  leaf_limit_q;
    logic [1:0]  cut_limit_q;

    map_result_t expected_results[$];
    int  send_idle_pct, recv_idle_pct;
    bit  failed = 0;
    int  quiet_cycles = 0;
    int  n_checked = 0;
    // ids declared or mapped so far, drawn from for well-formed fanins
    logic [11:0] known_ids[$];

    function automatic tb_cut_t trivial_cut(logic [11:0] id);
        tb_cut_t c;
        c.n = 1;
        foreach (c.lv[j]) c.lv[j] = '0;
        c.lv[0] = id;
        c.dly = tbl_delay[id];
        return c;
    endfunction

    function automatic tb_cut_t stored_cut(logic [11:0] id);
        tb_cut_t c;
        c.n = tbl_count[id] > 6 ? 6 : tbl_count[id];
        c.dly = 0;
        foreach (c.lv[j]) c.lv[j] = '0;
        for (int j = 0; j < c.n; j++) begin
            c.lv[j] = tbl_leaves[id][j];
            if (tbl_delay[c.lv[j]] > c.dly) c.dly = tbl_delay[c.lv[j]];
        end
        return c;
    endfunction

    // sorted union; returns 0 when it exceeds the leaf limit
    function automatic bit union_cut(tb_cut_t a, tb_cut_t b, int unsigned lim,
                                     output tb_cut_t o);
        int unsigned i, k, c, m;
        logic [11:0] v;
        i = 0; k = 0; c = 0;
        foreach (o.lv[j]) o.lv[j] = '0;
        o.n = 0; o.dly = 0;
        while (i < a.n || k < b.n) begin
            if (k >= b.n || (i < a.n && a.lv[i] < b.lv[k])) begin
                v = a.lv[i]; i++;
            end else if (i >= a.n || b.lv[k] < a.lv[i]) begin
                v = b.lv[k]; k++;
            end else begin
                v = a.lv[i]; i++; k++;
            end
            if (c >= lim) return 0;
            o.lv[c] = v; c++;
        end
        o.n = c;
        m = a.dly > b.dly ? a.dly : b.dly;
        o.dly = m >= 255 ? 255 : m + 1;
        return 1;
    endfunction

    function automatic map_result_t predict_node(logic [1:0] mode, logic [11:0] id,
                                                 logic [11:0] f0, logic [11:0] f1);
        map_result_t r;
        tb_cut_t c0[2], c1[2], m, best;
        int unsigned n0, n1, lim;
        bit have;
        r = '0;
        best.n = 0; best.dly = 0;
        foreach (best.lv[j]) best.lv[j] = '0;
        if (mode == MODE_DECL) begin
            tbl_delay[id] = 0;
            tbl_count[id] = 0;
        end else if (mode == MODE_MAP) begin
            lim = leaf_limit_q < 2 ? 2 : (leaf_limit_q > 6 ? 6 : leaf_limit_q);
            n0 = 1; n1 = 1; have = 0;
            c0[0] = trivial_cut(f0);
            c1[0] = trivial_cut(f1);
            if (cut_limit_q >= 2) begin
                if (tbl_count[f0] != 0) begin c0[1] = stored_cut(f0); n0 = 2; end
                if (tbl_count[f1] != 0) begin c1[1] = stored_cut(f1); n1 = 2; end
            end
            for (int i = 0; i < n0; i++)
                for (int k = 0; k < n1; k++)
                    if (union_cut(c0[i], c1[k], lim, m))
                        if (!have || m.dly < best.dly ||
                            (m.dly == best.dly && m.n < best.n)) begin
                            best = m;
                            have = 1;
                        end
            tbl_delay[id] = best.dly[7:0];
            tbl_count[id] = best.n[2:0];
            for (int j = 0; j < best.n; j++) tbl_leaves[id][j] = best.lv[j];
            r.cnt = best.n[2:0];
            for (int j = 0; j < 6; j++) r.lv[j] = best.lv[j];
        end else if (mode == MODE_OUT) begin
            best.dly = tbl_delay[id];
            if (tbl_delay[id] > worst_seen) worst_seen = tbl_delay[id];
        end
        r.node = id;
        r.dly = best.dly[7:0];
        r.worst = worst_seen;
        return r;
    endfunction

    // unpack m_tdata
    function automatic map_result_t unpack_result(logic [103:0] d);
        map_result_t r;
        r.node = d[11:0];
        r.dly = d[19:12];
        r.cnt = d[22:20];
        for (int j = 0; j < 6; j++) r.lv[j] = d[23 + 12*j +: 12];
        r.worst = d[102:95];
        return r;
    endfunction

    // drive one node transaction and record its prediction; s_tvalid stays high
    // until the next transaction or a drain
    task automatic send_node(logic [1:0] mode, logic [11:0] id,
                             logic [11:0] f0, logic [11:0] f1);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= {2'b0, f1, f0, id, mode};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_results.push_back(predict_node(mode, id, f0, f1));
        if (mode == MODE_DECL) known_ids.push_back(id);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    task automatic write_cfg(logic [0:0] idx, logic [2:0] val);
        drain();
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 0;
        if (idx == CFG_LEAF_LIMIT) leaf_limit_q = val;
        else cut_limit_q = val[1:0];
    endtask

    function automatic logic [11:0] pick_id();
        if (known_ids.size() != 0 && $urandom_range(9) < 8)
            return known_ids[$urandom_range(known_ids.size() - 1)];
        return 12'($urandom);
    endfunction

    // result checker
    always @(posedge aclk) begin
        map_result_t got, exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            got = unpack_result(m_tdata);
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                failed = 1;
            end else begin
                exp_r = expected_results.pop_front();
                n_checked++;
                if (got.node != exp_r.node || got.dly != exp_r.dly || got.cnt != exp_r.cnt
                    || got.lv != exp_r.lv || got.worst != exp_r.worst || m_tdata[103] !== 1'b0) begin
                    $display("%0t: mismatch expected %h actual %h", $time, exp_r, got);
                    failed = 1;
                end
            end
        end
    end

    // receiver stalls
    always @(posedge aclk) m_tready <= ($urandom_range(99) >= recv_idle_pct);

    // watchdog on cycles with no transaction
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic test_directed();
        // primary inputs at the id extremes and a plain chain
        send_node(MODE_DECL, 12'd0, 12'd0, 12'd0);
        send_node(MODE_DECL, 12'hFFF, 12'hFFF, 12'hFFF);
        send_node(MODE_DECL, 12'd5, 0, 0);
        send_node(MODE_DECL, 12'd9, 0, 0);
        send_node(MODE_MAP, 12'd20, 12'd0, 12'hFFF);
        send_node(MODE_MAP, 12'd21, 12'd5, 12'd9);
        send_node(MODE_MAP, 12'd22, 12'd20, 12'd21);
        send_node(MODE_MAP, 12'd23, 12'd22, 12'd22);
        send_node(MODE_MAP, 12'd24, 12'd23, 12'd20);
        // self and undeclared fanin
        send_node(MODE_MAP, 12'd30, 12'd30, 12'd999);
        send_node(MODE_OUT, 12'd24, 12'hFFF, 12'hFFF);
        send_node(MODE_OUT, 12'd777, 0, 0);
        // unused mode
        send_node(2'd3, 12'd24, 12'hABC, 12'h543);
        send_node(MODE_OUT, 12'd22, 0, 0);
    endtask

    // long chain on trivial cuts only, so each step adds a level up to saturation
    task automatic test_saturation();
        write_cfg(CFG_CUT_LIMIT, 2'd1);
        send_node(MODE_DECL, 12'd100, 0, 0);
        send_node(MODE_MAP, 12'd101, 12'd100, 12'd100);
        for (int i = 0; i < 260; i++)
            send_node(MODE_MAP, 12'd101, 12'd101, 12'd100);
        send_node(MODE_OUT, 12'd101, 0, 0);
        write_cfg(CFG_CUT_LIMIT, 2'd2);
    endtask

    task automatic test_random(int n);
        int r;
        logic [11:0] id;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            id = $urandom_range(1) ? 12'($urandom_range(63)) : 12'($urandom);
            if (r < 15) send_node(MODE_DECL, id, 12'($urandom), 12'($urandom));
            else if (r < 80) send_node(MODE_MAP, id, pick_id(), pick_id());
            else if (r < 97) send_node(MODE_OUT, pick_id(), 12'($urandom), 12'($urandom));
            else send_node(2'd3, id, 12'($urandom), 12'($urandom));
            // mapped nodes become fanin candidates
            if (r >= 15 && r < 80) known_ids.push_back(id);
        end
    endtask

    initial begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        worst_seen = 0;
        leaf_limit_q = 4;
        cut_limit_q = 2;
        for (int i = 0; i < NODE_COUNT; i++) begin
            tbl_delay[i] = 0;
            tbl_count[i] = 0;
        end
        repeat (7) @(posedge aclk);
        aresetn <= 1;

        send_idle_pct = 6; recv_idle_pct = 50;
        test_directed();
        test_saturation();
        test_random(150);
        write_cfg(CFG_LEAF_LIMIT, 3'd6);
        test_random(100);
        write_cfg(CFG_LEAF_LIMIT, 3'd2);
        send_idle_pct = 50; recv_idle_pct = 6;
        test_random(100);
        write_cfg(CFG_CUT_LIMIT, 2'd1);
        test_random(80);
        write_cfg(CFG_LEAF_LIMIT, 3'd0);
        write_cfg(CFG_CUT_LIMIT, 2'd3);
        test_random(80);
        send_idle_pct = 0; recv_idle_pct = 0;
        write_cfg(CFG_LEAF_LIMIT, 3'd7);
        write_cfg(CFG_CUT_LIMIT, 2'd0);
        test_random(80);
        write_cfg(CFG_LEAF_LIMIT, 3'd3);
        write_cfg(CFG_CUT_LIMIT, 2'd2);
        test_random(130);

        drain();
        if (!failed) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
